// ===== hdl/sdci_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, command codes and constants for the SD card bring-up sequencer.
// No dependencies; every other file of the block imports this package.
package sdci_pkg;

    // SD command indexes used by the sequence.
    localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
    localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
    localparam logic [5:0] CMD_SET_BUS_W   = 6'd6;
    localparam logic [5:0] CMD_SELECT      = 6'd7;
    localparam logic [5:0] CMD_SEND_IF     = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
    localparam logic [5:0] CMD_SEND_CID    = 6'd10;
    localparam logic [5:0] CMD_SET_BLKLEN  = 6'd16;
    localparam logic [5:0] CMD_OP_COND     = 6'd41;
    localparam logic [5:0] CMD_APP         = 6'd55;

    // Expected response length.
    localparam logic [1:0] RESP_NONE  = 2'd0;
    localparam logic [1:0] RESP_SHORT = 2'd1;
    localparam logic [1:0] RESP_LONG  = 2'd2;

    // Request kinds on the input side.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DONE  = 1'b1;

    // Command arguments and response values.
    localparam logic [31:0] ARG_IF_COND    = 32'h0000_01AA;
    localparam logic [31:0] ARG_OCR_HCS    = 32'h40FF_8000;
    localparam logic [31:0] ARG_OCR_STD    = 32'h00FF_8000;
    localparam logic [31:0] ARG_BLOCK_512  = 32'd512;
    localparam logic [31:0] ARG_BUS_4BIT   = 32'h0000_0002;
    localparam logic [31:0] RESP_SELECTED  = 32'h0000_0700;
    localparam int          OCR_BUSY_BIT   = 31;
    localparam int          OCR_CCS_BIT    = 30;

    typedef struct packed {
        logic        issue_cmd;
        logic [5:0]  cmd_index;
        logic [1:0]  word_select;
        logic [1:0]  response_kind;
        logic        check_response;
        logic [31:0] cmd_argument;
    } sdci_cmd_t;

    typedef struct packed {
        sdci_cmd_t   cmd;
        logic        init_done;
        logic        init_ok;
        logic        high_capacity;
        logic        spec_v2;
        logic [15:0] card_address;
        logic [31:0] sector_count;
    } sdci_result_t;

    function automatic sdci_cmd_t make_cmd(
        input logic [5:0]  idx,
        input logic [1:0]  wsel,
        input logic [1:0]  kind,
        input logic        chk,
        input logic [31:0] arg
    );
        sdci_cmd_t c;
        c.issue_cmd      = 1'b1;
        c.cmd_index      = idx;
        c.word_select    = wsel;
        c.response_kind  = kind;
        c.check_response = chk;
        c.cmd_argument   = arg;
        return c;
    endfunction

endpackage

// ===== hdl/sdci_capacity.sv =====
`timescale 1ns / 1ps
// Card capacity in 512-byte sectors from the two CSD words.
// Depends on sdci_pkg.
module sdci_capacity (
    input  logic        high_capacity,
    input  logic [9:0]  size_high_part,
    input  logic [3:0]  block_len_exp,
    input  logic [31:0] response_word,
    output logic [31:0] sector_count
);
    import sdci_pkg::*;

    logic [22:0] hc_size_plus;
    logic [12:0] sc_size_plus;
    logic [4:0]  sc_shift;
    logic [31:0] sc_bytes;

    always_comb
    begin
        // High capacity: (C_SIZE + 1) * 1024, wrapping at 32 bits.
        hc_size_plus = {1'b0, size_high_part[5:0], response_word[31:16]} + 23'd1;
        // Standard capacity: (C_SIZE + 1) << (size multiplier + 2 + block length exponent),
        // then / 512.
        sc_size_plus = {1'b0, size_high_part, response_word[31:30]} + 13'd1;
        sc_shift     = {2'b00, response_word[17:15]} + 5'd2 + {1'b0, block_len_exp};
        sc_bytes     = {19'd0, sc_size_plus} << sc_shift;
        if (high_capacity)
        begin
            sector_count = {hc_size_plus[21:0], 10'd0};
        end
        else
        begin
            sector_count = sc_bytes >> 9;
        end
    end

endmodule

// ===== hdl/sdci_step.sv =====
`timescale 1ns / 1ps
// Bring-up state machine: holds the sequence step and card facts, and forms the result.
// Depends on sdci_pkg and sdci_capacity.
module sdci_step (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic                  req_type,
    input  logic                  cmd_ok,
    input  logic [31:0]           response_word,
    output sdci_pkg::sdci_result_t result
);
    import sdci_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'd0,
        ST_CMD0   = 5'd1,
        ST_CMD8   = 5'd2,
        ST_APP    = 5'd3,
        ST_OPCOND = 5'd4,
        ST_CID    = 5'd5,
        ST_RCA    = 5'd6,
        ST_CSD1   = 5'd7,
        ST_CSD2   = 5'd8,
        ST_CIDW0  = 5'd9,
        ST_CIDW2  = 5'd10,
        ST_CIDW3  = 5'd11,
        ST_SELECT = 5'd12,
        ST_BLKLEN = 5'd13,
        ST_APP2   = 5'd14,
        ST_BUSW   = 5'd15
    } step_t;

    step_t       step_reg, step_next;
    logic        v2_reg, v2_next;
    logic        sdhc_reg, sdhc_next;
    logic [15:0] rca_reg, rca_next;
    logic [3:0]  bl_exp_reg, bl_exp_next;
    logic [9:0]  size_hi_reg, size_hi_next;
    logic [31:0] cap_reg, cap_next;
    logic [31:0] cap_calc;
    logic [31:0] addr_arg;
    sdci_cmd_t   cmd;
    logic        done;
    logic        ok_end;

    sdci_capacity u_capacity (
        .high_capacity  (sdhc_reg),
        .size_high_part (size_hi_reg),
        .block_len_exp  (bl_exp_reg),
        .response_word  (response_word),
        .sector_count   (cap_calc)
    );

    assign addr_arg = {rca_reg, 16'd0};

    always_comb
    begin
        step_next    = step_reg;
        v2_next      = v2_reg;
        sdhc_next    = sdhc_reg;
        rca_next     = rca_reg;
        bl_exp_next  = bl_exp_reg;
        size_hi_next = size_hi_reg;
        cap_next     = cap_reg;
        cmd          = '0;
        done         = 1'b0;
        ok_end       = 1'b0;
        if (req_type == REQ_START)
        begin
            // A start clears everything, even in the middle of a sequence.
            v2_next      = 1'b0;
            sdhc_next    = 1'b0;
            rca_next     = '0;
            bl_exp_next  = '0;
            size_hi_next = '0;
            cap_next     = '0;
            cmd          = make_cmd(CMD_GO_IDLE, 2'd0, RESP_NONE, 1'b0, 32'd0);
            step_next    = ST_CMD0;
        end
        else if (!cmd_ok && step_reg != ST_CMD8 && step_reg != ST_BUSW
                 && step_reg >= ST_CMD0 && step_reg <= ST_APP2)
        begin
            // Any failed command but CMD8 ends the sequence.
            done      = 1'b1;
            step_next = ST_IDLE;
        end
        else
        begin
            unique case (step_reg)
                ST_CMD0:
                begin
                    cmd       = make_cmd(CMD_SEND_IF, 2'd0, RESP_SHORT, 1'b1, ARG_IF_COND);
                    step_next = ST_CMD8;
                end
                ST_CMD8:
                begin
                    v2_next   = cmd_ok;
                    cmd       = make_cmd(CMD_APP, 2'd0, RESP_SHORT, 1'b1, 32'd0);
                    step_next = ST_APP;
                end
                ST_APP:
                begin
                    cmd       = make_cmd(CMD_OP_COND, 2'd0, RESP_SHORT, 1'b0,
                                         v2_reg ? ARG_OCR_HCS : ARG_OCR_STD);
                    step_next = ST_OPCOND;
                end
                ST_OPCOND:
                begin
                    if (!response_word[OCR_BUSY_BIT])
                    begin
                        cmd       = make_cmd(CMD_APP, 2'd0, RESP_SHORT, 1'b1, 32'd0);
                        step_next = ST_APP;
                    end
                    else
                    begin
                        sdhc_next = response_word[OCR_CCS_BIT];
                        cmd       = make_cmd(CMD_ALL_SEND_CID, 2'd0, RESP_LONG, 1'b0, 32'd0);
                        step_next = ST_CID;
                    end
                end
                ST_CID:
                begin
                    cmd       = make_cmd(CMD_SEND_RCA, 2'd0, RESP_SHORT, 1'b1, 32'd0);
                    step_next = ST_RCA;
                end
                ST_RCA:
                begin
                    rca_next  = response_word[31:16];
                    cmd       = make_cmd(CMD_SEND_CSD, 2'd1, RESP_LONG, 1'b0,
                                         {response_word[31:16], 16'd0});
                    step_next = ST_CSD1;
                end
                ST_CSD1:
                begin
                    if (sdhc_reg)
                    begin
                        size_hi_next = {4'd0, response_word[5:0]};
                    end
                    else
                    begin
                        bl_exp_next  = response_word[19:16];
                        size_hi_next = response_word[9:0];
                    end
                    cmd       = make_cmd(CMD_SEND_CSD, 2'd2, RESP_LONG, 1'b0, addr_arg);
                    step_next = ST_CSD2;
                end
                ST_CSD2:
                begin
                    cap_next  = cap_calc;
                    cmd       = make_cmd(CMD_SEND_CID, 2'd0, RESP_LONG, 1'b0, addr_arg);
                    step_next = ST_CIDW0;
                end
                ST_CIDW0:
                begin
                    cmd       = make_cmd(CMD_SEND_CID, 2'd2, RESP_LONG, 1'b0, addr_arg);
                    step_next = ST_CIDW2;
                end
                ST_CIDW2:
                begin
                    cmd       = make_cmd(CMD_SEND_CID, 2'd3, RESP_LONG, 1'b0, addr_arg);
                    step_next = ST_CIDW3;
                end
                ST_CIDW3:
                begin
                    cmd       = make_cmd(CMD_SELECT, 2'd0, RESP_SHORT, 1'b1, addr_arg);
                    step_next = ST_SELECT;
                end
                ST_SELECT:
                begin
                    if (response_word != RESP_SELECTED)
                    begin
                        done      = 1'b1;
                        step_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd       = make_cmd(CMD_SET_BLKLEN, 2'd0, RESP_SHORT, 1'b1,
                                             ARG_BLOCK_512);
                        step_next = ST_BLKLEN;
                    end
                end
                ST_BLKLEN:
                begin
                    cmd       = make_cmd(CMD_APP, 2'd0, RESP_SHORT, 1'b1, addr_arg);
                    step_next = ST_APP2;
                end
                ST_APP2:
                begin
                    cmd       = make_cmd(CMD_SET_BUS_W, 2'd0, RESP_SHORT, 1'b1, ARG_BUS_4BIT);
                    step_next = ST_BUSW;
                end
                ST_BUSW:
                begin
                    done      = 1'b1;
                    ok_end    = cmd_ok;
                    step_next = ST_IDLE;
                end
                default:
                begin
                    // Idle and unused codes: a completion is ignored.
                    step_next = ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        result.cmd           = cmd;
        result.init_done     = done;
        result.init_ok       = ok_end;
        result.high_capacity = sdhc_next;
        result.spec_v2       = v2_next;
        result.card_address  = rca_next;
        result.sector_count  = cap_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ST_IDLE;
            v2_reg      <= 1'b0;
            sdhc_reg    <= 1'b0;
            rca_reg     <= '0;
            bl_exp_reg  <= '0;
            size_hi_reg <= '0;
            cap_reg     <= '0;
        end
        else if (take)
        begin
            step_reg    <= step_next;
            v2_reg      <= v2_next;
            sdhc_reg    <= sdhc_next;
            rca_reg     <= rca_next;
            bl_exp_reg  <= bl_exp_next;
            size_hi_reg <= size_hi_next;
            cap_reg     <= cap_next;
        end
    end

endmodule

// ===== hdl/sd_card_init_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Top level of the SD card bring-up sequencer: stream ports, input and result registers.
// Depends on sdci_pkg and sdci_step.
//
//  Channel   Direction  Signals                            Moves
//  s_*       in         s_tvalid s_tready s_tuser s_tdata  start request or command outcome
//  m_*       out        m_tvalid m_tready m_tdata          next command and card status
//
// Every input transfer yields exactly one output transfer. Throughput is one item per
// clock unless m_tready stalls: the input register feeds the step logic, whose result
// lands in the output register, and m_tvalid rises once an item has passed both.
// rst_n clears the sequence to idle and both valid flags; the card facts reset to zero.
// A stall on m_tready holds the result register and then the input register; s_tready
// drops only when both are full and m_tready is low.
module sd_card_init_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // req_type
    input  logic [39:0] s_tdata,   // cmd_ok, response_word, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    // issue_cmd, cmd_index, word_select, response_kind, check_response, cmd_argument,
    // init_done, init_ok, high_capacity, spec_v2, card_address, sector_count
    output logic [95:0] m_tdata
);
    import sdci_pkg::*;

    logic         in_vld_reg;
    logic         in_req_reg;
    logic         in_ok_reg;
    logic [31:0]  in_resp_reg;
    logic         out_vld_reg;
    sdci_result_t out_reg;
    sdci_result_t step_result;
    logic         advance;

    // The held item moves on when the result register is empty or being drained.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;

    sdci_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (advance),
        .req_type      (in_req_reg),
        .cmd_ok        (in_ok_reg),
        .response_word (in_resp_reg),
        .result        (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg  <= s_tuser;
            in_ok_reg   <= s_tdata[0];
            in_resp_reg <= s_tdata[32:1];
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign m_tdata = {out_reg.sector_count,
                      out_reg.card_address,
                      out_reg.spec_v2,
                      out_reg.high_capacity,
                      out_reg.init_ok,
                      out_reg.init_done,
                      out_reg.cmd.cmd_argument,
                      out_reg.cmd.check_response,
                      out_reg.cmd.response_kind,
                      out_reg.cmd.word_select,
                      out_reg.cmd.cmd_index,
                      out_reg.cmd.issue_cmd};

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("processed item did not reach the result register");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && out_vld_reg && !m_tready |=> in_vld_reg)
        else $error("held input item lost during an output stall");

    a_done_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.init_done |-> !out_reg.cmd.issue_cmd)
        else $error("ending result also issues a command");

    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.init_ok |-> out_reg.init_done)
        else $error("success flagged without the end of the sequence");

endmodule

// ===== tb/sdci_bringup_checker.sv =====
`timescale 1ns / 1ps
// Checker for the SD card bring-up sequencer: watches both stream channels, predicts each result.
// Depends on sdci_pkg for the command codes, response kinds and the result struct.
module sdci_bringup_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        s_tuser,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    output int          mismatch_count,
    output int          pending,
    output int          results_seen,
    output int          bringups_ok,
    output int          bringups_failed
);
    import sdci_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_CMD0   = 5'd1,
        PH_CMD8   = 5'd2,
        PH_APP    = 5'd3,
        PH_OPCOND = 5'd4,
        PH_CID    = 5'd5,
        PH_RCA    = 5'd6,
        PH_CSD1   = 5'd7,
        PH_CSD2   = 5'd8,
        PH_CIDW0  = 5'd9,
        PH_CIDW2  = 5'd10,
        PH_CIDW3  = 5'd11,
        PH_SELECT = 5'd12,
        PH_BLKLEN = 5'd13,
        PH_APP2   = 5'd14,
        PH_BUSW   = 5'd15
    } bringup_phase_t;

    bringup_phase_t phase;
    logic           v2_card;
    logic           hc_card;
    logic [15:0]    rca;
    logic [3:0]     blk_len_exp;
    logic [9:0]     csize_upper;
    logic [31:0]    sectors;

    sdci_result_t   awaited_results[$];
    sdci_result_t   want;
    sdci_result_t   got;
    bit             field_bad;

    function automatic sdci_cmd_t issue(input logic [5:0] idx, input logic [1:0] wsel,
                                        input logic [1:0] kind, input logic chk,
                                        input logic [31:0] arg);
        sdci_cmd_t c;
        c.issue_cmd      = 1'b1;
        c.cmd_index      = idx;
        c.word_select    = wsel;
        c.response_kind  = kind;
        c.check_response = chk;
        c.cmd_argument   = arg;
        return c;
    endfunction

    task automatic clear_card_facts();
        phase       = PH_IDLE;
        v2_card     = 1'b0;
        hc_card     = 1'b0;
        rca         = '0;
        blk_len_exp = '0;
        csize_upper = '0;
        sectors     = '0;
    endtask

    task automatic conclude(inout sdci_result_t r, input logic success);
        r.init_done = 1'b1;
        r.init_ok   = success;
        phase       = PH_IDLE;
    endtask

    // Works out the command that follows one request and moves the sequence on.
    task automatic next_bringup_command(input logic req, input logic ok,
                                        input logic [31:0] resp, output sdci_result_t r);
        logic [31:0] addr_arg;
        logic [21:0] hc_size;
        logic [11:0] sc_size;
        logic [2:0]  size_mult;
        logic [31:0] scaled;
        r        = '0;
        addr_arg = {rca, 16'h0000};
        if (req == REQ_START) begin
            clear_card_facts();
            r.cmd = issue(CMD_GO_IDLE, 2'd0, RESP_NONE, 1'b0, 32'd0);
            phase = PH_CMD0;
        end
        else begin
            case (phase)
                PH_IDLE: ;
                PH_CMD8:
                begin
                    // A card that does not answer CMD8 is simply an older one.
                    v2_card = ok;
                    r.cmd   = issue(CMD_APP, 2'd0, RESP_SHORT, 1'b1, 32'd0);
                    phase   = PH_APP;
                end
                PH_BUSW: conclude(r, ok);
                default:
                begin
                    if (!ok || (phase == PH_SELECT && resp != RESP_SELECTED))
                        conclude(r, 1'b0);
                    else begin
                        case (phase)
                            PH_CMD0:
                            begin
                                r.cmd = issue(CMD_SEND_IF, 2'd0, RESP_SHORT, 1'b1, ARG_IF_COND);
                                phase = PH_CMD8;
                            end
                            PH_APP:
                            begin
                                r.cmd = issue(CMD_OP_COND, 2'd0, RESP_SHORT, 1'b0,
                                              v2_card ? ARG_OCR_HCS : ARG_OCR_STD);
                                phase = PH_OPCOND;
                            end
                            PH_OPCOND:
                            begin
                                if (!resp[OCR_BUSY_BIT]) begin
                                    r.cmd = issue(CMD_APP, 2'd0, RESP_SHORT, 1'b1, 32'd0);
                                    phase = PH_APP;
                                end
                                else begin
                                    hc_card = resp[OCR_CCS_BIT];
                                    r.cmd   = issue(CMD_ALL_SEND_CID, 2'd0, RESP_LONG, 1'b0,
                                                    32'd0);
                                    phase   = PH_CID;
                                end
                            end
                            PH_CID:
                            begin
                                r.cmd = issue(CMD_SEND_RCA, 2'd0, RESP_SHORT, 1'b1, 32'd0);
                                phase = PH_RCA;
                            end
                            PH_RCA:
                            begin
                                rca   = resp[31:16];
                                r.cmd = issue(CMD_SEND_CSD, 2'd1, RESP_LONG, 1'b0,
                                              {resp[31:16], 16'h0000});
                                phase = PH_CSD1;
                            end
                            PH_CSD1:
                            begin
                                if (hc_card)
                                    csize_upper = {4'd0, resp[5:0]};
                                else begin
                                    blk_len_exp = resp[19:16];
                                    csize_upper = resp[9:0];
                                end
                                r.cmd = issue(CMD_SEND_CSD, 2'd2, RESP_LONG, 1'b0, addr_arg);
                                phase = PH_CSD2;
                            end
                            PH_CSD2:
                            begin
                                if (hc_card) begin
                                    hc_size = {csize_upper[5:0], resp[31:16]};
                                    sectors = ({10'd0, hc_size} + 32'd1) << 10;
                                end
                                else begin
                                    // Both shifts wrap at 32 bits before the final divide.
                                    sc_size   = {csize_upper, resp[31:30]};
                                    size_mult = resp[17:15];
                                    scaled    = ({20'd0, sc_size} + 32'd1)
                                                << ({1'b0, size_mult} + 4'd2);
                                    scaled    = scaled << blk_len_exp;
                                    sectors   = scaled >> 9;
                                end
                                r.cmd = issue(CMD_SEND_CID, 2'd0, RESP_LONG, 1'b0, addr_arg);
                                phase = PH_CIDW0;
                            end
                            PH_CIDW0:
                            begin
                                r.cmd = issue(CMD_SEND_CID, 2'd2, RESP_LONG, 1'b0, addr_arg);
                                phase = PH_CIDW2;
                            end
                            PH_CIDW2:
                            begin
                                r.cmd = issue(CMD_SEND_CID, 2'd3, RESP_LONG, 1'b0, addr_arg);
                                phase = PH_CIDW3;
                            end
                            PH_CIDW3:
                            begin
                                r.cmd = issue(CMD_SELECT, 2'd0, RESP_SHORT, 1'b1, addr_arg);
                                phase = PH_SELECT;
                            end
                            PH_SELECT:
                            begin
                                r.cmd = issue(CMD_SET_BLKLEN, 2'd0, RESP_SHORT, 1'b1,
                                              ARG_BLOCK_512);
                                phase = PH_BLKLEN;
                            end
                            PH_BLKLEN:
                            begin
                                r.cmd = issue(CMD_APP, 2'd0, RESP_SHORT, 1'b1, addr_arg);
                                phase = PH_APP2;
                            end
                            PH_APP2:
                            begin
                                r.cmd = issue(CMD_SET_BUS_W, 2'd0, RESP_SHORT, 1'b1,
                                              ARG_BUS_4BIT);
                                phase = PH_BUSW;
                            end
                            default: phase = PH_IDLE;
                        endcase
                    end
                end
            endcase
        end
        r.high_capacity = hc_card;
        r.spec_v2       = v2_card;
        r.card_address  = rca;
        r.sector_count  = sectors;
    endtask

    task automatic note_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
        if (want_v !== got_v) begin
            if (mismatch_count < 10)
                $display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, name, want_v, got_v);
            field_bad = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_card_facts();
            awaited_results.delete();
            mismatch_count  = 0;
            pending         = 0;
            results_seen    = 0;
            bringups_ok     = 0;
            bringups_failed = 0;
        end
        else begin
            // A result never leaves at the edge that accepts its request, so check first.
            if (m_tvalid && m_tready) begin
                got.cmd.issue_cmd      = m_tdata[0];
                got.cmd.cmd_index      = m_tdata[6:1];
                got.cmd.word_select    = m_tdata[8:7];
                got.cmd.response_kind  = m_tdata[10:9];
                got.cmd.check_response = m_tdata[11];
                got.cmd.cmd_argument   = m_tdata[43:12];
                got.init_done          = m_tdata[44];
                got.init_ok            = m_tdata[45];
                got.high_capacity      = m_tdata[46];
                got.spec_v2            = m_tdata[47];
                got.card_address       = m_tdata[63:48];
                got.sector_count       = m_tdata[95:64];
                results_seen++;
                if (awaited_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result 0x%0h arrived with none outstanding",
                                 $realtime, m_tdata);
                    mismatch_count++;
                end
                else begin
                    want      = awaited_results.pop_front();
                    field_bad = 1'b0;
                    note_field("issue_cmd", 32'(want.cmd.issue_cmd), 32'(got.cmd.issue_cmd));
                    note_field("cmd_index", 32'(want.cmd.cmd_index), 32'(got.cmd.cmd_index));
                    note_field("word_select", 32'(want.cmd.word_select),
                               32'(got.cmd.word_select));
                    note_field("response_kind", 32'(want.cmd.response_kind),
                               32'(got.cmd.response_kind));
                    note_field("check_response", 32'(want.cmd.check_response),
                               32'(got.cmd.check_response));
                    note_field("cmd_argument", want.cmd.cmd_argument, got.cmd.cmd_argument);
                    note_field("init_done", 32'(want.init_done), 32'(got.init_done));
                    note_field("init_ok", 32'(want.init_ok), 32'(got.init_ok));
                    note_field("high_capacity", 32'(want.high_capacity),
                               32'(got.high_capacity));
                    note_field("spec_v2", 32'(want.spec_v2), 32'(got.spec_v2));
                    note_field("card_address", 32'(want.card_address), 32'(got.card_address));
                    note_field("sector_count", want.sector_count, got.sector_count);
                    if (field_bad)
                        mismatch_count++;
                    if (want.init_done && want.init_ok)
                        bringups_ok++;
                    else if (want.init_done)
                        bringups_failed++;
                end
            end
            if (s_tvalid && s_tready) begin
                next_bringup_command(s_tuser, s_tdata[0], s_tdata[32:1], want);
                awaited_results.push_back(want);
            end
            pending = awaited_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the bring-up sequencer testbench: clock, reset, card-side stimulus and the verdict.
// Depends on sdci_pkg, sd_card_init_sequencer_unit and sdci_bringup_checker.
module tb_top;

    import sdci_pkg::*;

    // Clock and the single reset at the start of the run.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    // Request channel: tuser carries req_type, tdata carries cmd_ok then response_word.
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;
    logic [39:0] s_tdata = '0;

    // Result channel: next command and the card status, one transfer per request.
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;

    int          mismatch_count;
    int          pending;
    int          results_seen;
    int          bringups_ok;
    int          bringups_failed;

    // Stimulus bookkeeping. The session variables describe how the emulated card
    // behaves in the bring-up that is being driven right now.
    int          items_driven;
    int          session_items;
    int          answer_idx;
    int          fail_at_g;
    int          abort_at_g;
    bit          session_over;
    bit          aborted_g;
    bit          src_quiet;
    bit          sink_quiet;
    int          sink_hold;
    int          drain_wait;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sd_card_init_sequencer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sdci_bringup_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tuser         (s_tuser),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .pending         (pending),
        .results_seen    (results_seen),
        .bringups_ok     (bringups_ok),
        .bringups_failed (bringups_failed)
    );

    // Result side back-pressure. After every transfer the sink draws a random hold and
    // keeps tready low while it counts down, unless the current session runs it quiet.
    always @(posedge clk or negedge rst_n)
    begin : sink_side
        int hold;
        if (!rst_n) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end
        else if (m_tvalid && m_tready) begin
            hold = sink_quiet ? 0 : $urandom_range(0, 19);
            sink_hold <= hold;
            m_tready  <= (hold == 0);
        end
        else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= (sink_hold == 1);
        end
        else
            m_tready <= 1'b1;
    end

    // Moves one request across the input channel. The caller always stands at a
    // rising edge, and so does this task when it returns. With no gap drawn, valid
    // simply stays high and only the payload changes.
    task automatic send_item(input logic req, input logic ok, input logic [31:0] resp);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, resp, ok};
        do
            @(posedge clk);
        while (!s_tready);
        items_driven++;
    endtask

    // A response word from the card: all ones for the extreme directed runs,
    // otherwise random.
    function automatic logic [31:0] card_word(input bit max_data);
        return max_data ? 32'hFFFF_FFFF : $urandom();
    endfunction

    // Reports the outcome of the command the sequencer issued last. The session may
    // fail a command at a chosen position, or walk away at another position so that
    // the next start request lands in the middle of a bring-up. A refused CMD8 is the
    // only failure after which the sequence keeps going.
    task automatic answer(input logic [31:0] resp, input bit refuse, input bit survives);
        logic ok;
        if (session_over)
            return;
        if (answer_idx == abort_at_g) begin
            session_over = 1'b1;
            aborted_g    = 1'b1;
            return;
        end
        ok = !(refuse || answer_idx == fail_at_g);
        send_item(REQ_DONE, ok, ok ? resp : $urandom());
        session_items++;
        answer_idx++;
        if (!ok && !survives)
            session_over = 1'b1;
    endtask

    // One bring-up as a card would answer it, in the order the commands come out:
    // CMD0, CMD8, a number of not-yet-ready ACMD41 polls, the ready poll, CMD2, CMD3,
    // two CSD words, three CID words, CMD7, CMD16, CMD55 and ACMD6.
    task automatic run_session(input int fail_at, input int abort_at, input bit bad_select,
                               input bit v2_card, input int polls, input bit hc,
                               input bit max_data);
        logic [31:0] w;
        answer_idx   = 0;
        fail_at_g    = fail_at;
        abort_at_g   = abort_at;
        session_over = 1'b0;
        aborted_g    = 1'b0;
        send_item(REQ_START, 1'($urandom_range(0, 1)), card_word(max_data));
        session_items++;
        answer(card_word(max_data), 1'b0, 1'b0);          // CMD0
        answer(card_word(max_data), !v2_card, 1'b1);      // CMD8
        repeat (polls) begin
            answer(card_word(max_data), 1'b0, 1'b0);      // CMD55
            w = card_word(max_data);
            w[OCR_BUSY_BIT] = 1'b0;
            answer(w, 1'b0, 1'b0);                        // ACMD41, card still busy
        end
        answer(card_word(max_data), 1'b0, 1'b0);          // CMD55
        w = card_word(max_data);
        w[OCR_BUSY_BIT] = 1'b1;
        w[OCR_CCS_BIT]  = hc;
        answer(w, 1'b0, 1'b0);                            // ACMD41, card ready
        answer(card_word(max_data), 1'b0, 1'b0);          // CMD2
        answer(card_word(max_data), 1'b0, 1'b0);          // CMD3, address in the top half
        answer(card_word(max_data), 1'b0, 1'b0);          // CSD word 1
        answer(card_word(max_data), 1'b0, 1'b0);          // CSD word 2
        repeat (3)
            answer(card_word(max_data), 1'b0, 1'b0);      // CID words
        if (bad_select) begin
            // Either a random word or the expected value with one bit wrong.
            if ($urandom_range(0, 1) == 0)
                w = $urandom();
            else
                w = RESP_SELECTED ^ (32'd1 << $urandom_range(0, 31));
            if (w == RESP_SELECTED)
                w = w ^ 32'd1;
        end
        else
            w = RESP_SELECTED;
        answer(w, 1'b0, 1'b0);                            // CMD7
        if (bad_select)
            session_over = 1'b1;
        answer(card_word(max_data), 1'b0, 1'b0);          // CMD16
        answer(card_word(max_data), 1'b0, 1'b0);          // CMD55
        answer(card_word(max_data), 1'b0, 1'b0);          // ACMD6
        // A completion that arrives once the sequence has ended must be ignored.
        if (!aborted_g && $urandom_range(0, 4) == 0)
            send_item(REQ_DONE, 1'($urandom_range(0, 1)), $urandom());
    endtask

    initial
    begin
        items_driven  = 0;
        session_items = 0;
        src_quiet     = 1'b0;
        sink_quiet    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. A completion straight after reset finds the sequencer idle.
        send_item(REQ_DONE, 1'b1, 32'hFFFF_FFFF);
        // A complete high-capacity bring-up with every response word at all ones: the
        // card address is 0xFFFF and the sector count wraps to zero.
        run_session(-1, -1, 1'b0, 1'b1, 0, 1'b1, 1'b1);
        // An old card refuses CMD8, then the first CMD55 fails and ends the sequence.
        run_session(2, -1, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        // Walk away after CMD0 so that the next start arrives mid-sequence.
        run_session(-1, 1, 1'b0, 1'b1, 0, 1'b0, 1'b0);

        // Random part: mostly well-formed bring-ups with random card contents, some
        // with a failed command, a bad select response or a restart, plus bursts of
        // unrelated requests. Some sessions run one side or both without idling.
        while (session_items < 1900) begin
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom());
            end
            else
                run_session(($urandom_range(0, 2) == 0) ? $urandom_range(0, 22) : -1,
                            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : -1,
                            ($urandom_range(0, 11) == 0),
                            ($urandom_range(0, 9) < 7),
                            ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15)
                                                        : $urandom_range(0, 3),
                            1'($urandom_range(0, 1)),
                            1'b0);
        end
        s_tvalid <= 1'b0;

        // Let the outstanding results drain, then wait on for any stray transfer the
        // sequencer should not produce.
        drain_wait = 0;
        while (pending != 0 && drain_wait < 5000) begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (20) @(posedge clk);

        $display("Drove %0d requests (%0d in bring-up sessions); checked %0d results.",
                 items_driven, session_items, results_seen);
        $display("Sequences ended: %0d completed, %0d failed along the way.",
                 bringups_ok, bringups_failed);
        if (mismatch_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: the slowest legal run stays far below this.
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
